// ===== rtl/hptc_pkg.sv =====
// ---------------------------------------------------------------------------
// hptc_pkg
// Shared constants, types and partial-product helpers for the
// humidity/pressure/temperature compensation pipeline.
// ---------------------------------------------------------------------------
package hptc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM_A   = 3'd4;
  localparam logic [2:0] REG_HUM_B   = 3'd5;

  localparam int CFG_W   = 48;
  localparam int DIV_W   = 64;   // divider width, one quotient bit per stage
  localparam int NSTG    = 81;   // register stages from input to output
  localparam int TT_LEN  = 77;   // temperature delay taps, stage 4 to output
  localparam int HUM_LEN = 69;   // humidity delay taps, stage 12 to output

  localparam logic [16:0] HUM_MAX   = 17'd102400;
  localparam logic [31:0] HUM_CLAMP = 32'd419430400;

  typedef struct packed {
    logic signed [26:0] tc;
    logic signed [31:0] tf;
  } temp_t;

  // low partial of a 64 bit word slice times a signed 16 bit factor
  function automatic logic signed [63:0] part_lo(input logic [31:0] a,
                                                 input logic signed [15:0] b);
    logic signed [48:0] p;
    p = $signed({1'b0, a}) * b;
    return {{15{p[48]}}, p};
  endfunction

  // high partial, only the bits that land below bit 64 matter
  function automatic logic [31:0] part_hi(input logic [31:0] a,
                                          input logic signed [15:0] b);
    logic [31:0] bx;
    bx = {{16{b[15]}}, b};
    return a * bx;
  endfunction

endpackage

// ===== rtl/humidity_pressure_temp_compensation.sv =====
// throughput: one request per cycle while the output is not stalled; the 64-stage
//   restoring divider for the pressure quotient sets the depth, every stage holds one request
// the whole pipeline stalls together while a result waits on out_ready
// reset (synchronous, rst_n low) clears the valid bits and calibration words
// ---------------------------------------------------------------------------
// humidity_pressure_temp_compensation
// Integer compensation of raw temperature, humidity and pressure readings
// with packed calibration words, fully pipelined.
// ---------------------------------------------------------------------------
module humidity_pressure_temp_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  input  logic [15:0]        in_raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [26:0] out_temperature_centi,
  output logic signed [31:0] out_fine_temperature,
  output logic [16:0]        out_humidity_q22_10,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_pressure_invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  logic en;
  logic vld_r [1:hptc_pkg::NSTG];

  // calibration registers
  logic [47:0] cal_t_r, cal_pa_r, cal_pb_r, cal_pc_r;
  logic [31:0] cal_ha_r, cal_hb_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r  <= '0;
      cal_pa_r <= '0;
      cal_pb_r <= '0;
      cal_pc_r <= '0;
      cal_ha_r <= '0;
      cal_hb_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hptc_pkg::REG_TEMP:    cal_t_r  <= cfg_data;
        hptc_pkg::REG_PRESS_A: cal_pa_r <= cfg_data;
        hptc_pkg::REG_PRESS_B: cal_pb_r <= cfg_data;
        hptc_pkg::REG_PRESS_C: cal_pc_r <= cfg_data;
        hptc_pkg::REG_HUM_A:   cal_ha_r <= cfg_data[31:0];
        hptc_pkg::REG_HUM_B:   cal_hb_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [31:0] t2s, t3s, h1s, h2s, h3s, h4s, h5s, h6s;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [63:0] p4x;

  assign t1  = cal_t_r[15:0];
  assign t2s = {{16{cal_t_r[31]}}, cal_t_r[31:16]};
  assign t3s = {{16{cal_t_r[47]}}, cal_t_r[47:32]};
  assign p1  = cal_pa_r[15:0];
  assign p2  = cal_pa_r[31:16];
  assign p3  = cal_pa_r[47:32];
  assign p4  = cal_pb_r[15:0];
  assign p5  = cal_pb_r[31:16];
  assign p6  = cal_pb_r[47:32];
  assign p7  = cal_pc_r[15:0];
  assign p8  = cal_pc_r[31:16];
  assign p9  = cal_pc_r[47:32];
  assign p4x = {{48{p4[15]}}, p4};
  assign h1s = {24'b0, cal_ha_r[7:0]};
  assign h2s = {{16{cal_ha_r[23]}}, cal_ha_r[23:8]};
  assign h3s = {24'b0, cal_ha_r[31:24]};
  assign h4s = {{20{cal_hb_r[11]}}, cal_hb_r[11:0]};
  assign h5s = {{20{cal_hb_r[23]}}, cal_hb_r[23:12]};
  assign h6s = {{24{cal_hb_r[31]}}, cal_hb_r[31:24]};

  // global advance: the whole pipe moves unless the output is blocked
  assign en       = !vld_r[hptc_pkg::NSTG] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= hptc_pkg::NSTG; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int i = 2; i <= hptc_pkg::NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // ---------------- temperature ----------------
  logic signed [31:0] at1, d1;
  logic signed [31:0] s1_aprod_r, s1_dd_r, s2_a_r, s2_b_r, s3_tf_r;
  logic [15:0]        adch_r [1:4];
  logic [19:0]        adcp_r [1:7];

  assign at1 = {15'b0, in_raw_temperature[19:3]} - {15'b0, t1, 1'b0};
  assign d1  = {16'b0, in_raw_temperature[19:4]} - {16'b0, t1};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_aprod_r <= at1 * t2s;
      s1_dd_r    <= d1 * d1;
      adch_r[1]  <= in_raw_humidity;
      adcp_r[1]  <= in_raw_pressure;
      for (int i = 2; i <= 4; i++) adch_r[i] <= adch_r[i-1];
      for (int i = 2; i <= 7; i++) adcp_r[i] <= adcp_r[i-1];
      s2_a_r     <= s1_aprod_r >>> 11;
      s2_b_r     <= (s1_dd_r >>> 12) * t3s;
      s3_tf_r    <= s2_a_r + (s2_b_r >>> 14);
    end
  end

  // ---------------- stage 4: shared by all three formulas ----------------
  logic signed [31:0] v4, tc4;
  logic signed [32:0] v1_4;
  hptc_pkg::temp_t    tt_r [0:hptc_pkg::TT_LEN-1];
  logic signed [31:0] s4_h5v_r, s4_vh6_r, s4_vh3_r;
  logic signed [32:0] s4_v1_r;

  assign v4   = s3_tf_r - 32'sd76800;
  assign tc4  = ((s3_tf_r <<< 2) + s3_tf_r + 32'sd128) >>> 8;
  assign v1_4 = {s3_tf_r[31], s3_tf_r} - 33'sd128000;

  always_ff @(posedge clk) begin
    if (en) begin
      tt_r[0].tc <= tc4[26:0];
      tt_r[0].tf <= s3_tf_r;
      for (int i = 1; i < hptc_pkg::TT_LEN; i++) tt_r[i] <= tt_r[i-1];
      s4_h5v_r <= h5s * v4;
      s4_vh6_r <= v4 * h6s;
      s4_vh3_r <= v4 * h3s;
      s4_v1_r  <= v1_4;
    end
  end

  // ---------------- humidity ----------------
  logic signed [31:0] xsum5, x_r [5:8], s5_y_r, s5_z_r, s6_yz_r, s7_wp_r, s8_w_r;
  logic signed [31:0] s9_hv_r, s10_hv_r, s10_hss_r, s11_hv_r, s11_q_r, hv12, hs10;
  logic [16:0]        hum_r [0:hptc_pkg::HUM_LEN-1];
  logic [16:0]        hum12;

  assign xsum5 = {2'b0, adch_r[4], 14'b0} - (h4s <<< 20) - s4_h5v_r + 32'sd16384;
  assign hs10  = s9_hv_r >>> 15;
  assign hv12  = s11_hv_r - ((s11_q_r) >>> 4);

  // clamp to 0..100 percent before the final scale
  always_comb begin
    if (hv12[31])
      hum12 = '0;
    else if (hv12 > $signed(hptc_pkg::HUM_CLAMP))
      hum12 = hptc_pkg::HUM_MAX;
    else
      hum12 = hv12[28:12];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[5]    <= xsum5 >>> 15;
      for (int i = 6; i <= 8; i++) x_r[i] <= x_r[i-1];
      s5_y_r    <= s4_vh6_r >>> 10;
      s5_z_r    <= (s4_vh3_r >>> 11) + 32'sd32768;
      s6_yz_r   <= s5_y_r * s5_z_r;
      s7_wp_r   <= ((s6_yz_r >>> 10) + 32'sd2097152) * h2s;
      s8_w_r    <= (s7_wp_r + 32'sd8192) >>> 14;
      s9_hv_r   <= x_r[8] * s8_w_r;
      s10_hv_r  <= s9_hv_r;
      s10_hss_r <= hs10 * hs10;
      s11_hv_r  <= s10_hv_r;
      s11_q_r   <= (s10_hss_r >>> 7) * h1s;
      hum_r[0]  <= hum12;
      for (int i = 1; i < hptc_pkg::HUM_LEN; i++) hum_r[i] <= hum_r[i-1];
    end
  end

  // ---------------- pressure, ahead of the divider ----------------
  logic signed [65:0] sq5;
  logic signed [63:0] s5_v1sq_r, s5_v1p5_r, s5_v1p2_r;
  logic signed [63:0] s6_v2lo_r, s6_v3lo_r, s6_v1p5_r, s6_v1p2_r;
  logic [31:0]        s6_v2hi_r, s6_v3hi_r;
  logic signed [63:0] v3sum7, s7_v2_r, s7_v1b_r;
  logic [63:0]        c8;
  logic [20:0]        pr8;
  logic [47:0]        s8_clo_r;
  logic [31:0]        s8_chi_r;
  logic signed [63:0] s8_n0_r, csum9, s9_dv_r, s10_dv_r, s10_num_r;
  logic [44:0]        s9_nlo_r;
  logic [31:0]        s9_nhi_r;

  assign sq5    = s4_v1_r * s4_v1_r;
  assign v3sum7 = s6_v3lo_r + {s6_v3hi_r, 32'b0};
  assign c8     = s7_v1b_r + 64'sh0000_8000_0000_0000;
  assign pr8    = 21'h100000 - {1'b0, adcp_r[7]};
  assign csum9  = {16'b0, s8_clo_r} + {s8_chi_r, 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      s5_v1sq_r <= sq5[63:0];
      s5_v1p5_r <= s4_v1_r * p5;
      s5_v1p2_r <= s4_v1_r * p2;
      s6_v2lo_r <= hptc_pkg::part_lo(s5_v1sq_r[31:0], p6);
      s6_v2hi_r <= hptc_pkg::part_hi(s5_v1sq_r[63:32], p6);
      s6_v3lo_r <= hptc_pkg::part_lo(s5_v1sq_r[31:0], p3);
      s6_v3hi_r <= hptc_pkg::part_hi(s5_v1sq_r[63:32], p3);
      s6_v1p5_r <= s5_v1p5_r;
      s6_v1p2_r <= s5_v1p2_r;
      s7_v2_r   <= s6_v2lo_r + {s6_v2hi_r, 32'b0} + (s6_v1p5_r <<< 17) + (p4x <<< 35);
      s7_v1b_r  <= (v3sum7 >>> 8) + (s6_v1p2_r <<< 12);
      s8_clo_r  <= c8[31:0] * p1;
      s8_chi_r  <= c8[63:32] * {16'b0, p1};
      s8_n0_r   <= {12'b0, pr8, 31'b0} - s7_v2_r;
      s9_dv_r   <= csum9 >>> 33;
      s9_nlo_r  <= s8_n0_r[31:0] * 12'd3125;
      s9_nhi_r  <= s8_n0_r[63:32] * 32'd3125;
      s10_dv_r  <= s9_dv_r;
      s10_num_r <= {19'b0, s9_nlo_r} + {s9_nhi_r, 32'b0};
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [63:0] div_rem_r [0:hptc_pkg::DIV_W];
  logic [63:0] div_quo_r [0:hptc_pkg::DIV_W];
  logic [63:0] div_dsr_r [0:hptc_pkg::DIV_W];
  logic        div_neg_r [0:hptc_pkg::DIV_W];
  logic        div_inv_r [0:hptc_pkg::DIV_W];
  logic [64:0] div_try   [0:hptc_pkg::DIV_W-1];

  always_comb begin
    for (int k = 0; k < hptc_pkg::DIV_W; k++)
      div_try[k] = {div_rem_r[k], div_quo_r[k][63]} - {1'b0, div_dsr_r[k]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and signs
      div_rem_r[0] <= '0;
      div_quo_r[0] <= s10_num_r[63] ? 64'(-s10_num_r) : s10_num_r;
      div_dsr_r[0] <= s10_dv_r[63] ? 64'(-s10_dv_r) : s10_dv_r;
      div_neg_r[0] <= s10_num_r[63] ^ s10_dv_r[63];
      div_inv_r[0] <= (s10_dv_r == '0);
      for (int k = 0; k < hptc_pkg::DIV_W; k++) begin
        div_rem_r[k+1] <= div_try[k][64] ? {div_rem_r[k][62:0], div_quo_r[k][63]}
                                         : div_try[k][63:0];
        div_quo_r[k+1] <= {div_quo_r[k][62:0], !div_try[k][64]};
        div_dsr_r[k+1] <= div_dsr_r[k];
        div_neg_r[k+1] <= div_neg_r[k];
        div_inv_r[k+1] <= div_inv_r[k];
      end
    end
  end

  // ---------------- pressure, after the divider ----------------
  logic signed [63:0] q64, p_r [76:80], ps77, s77_ll_r, s78_psq_r, s78_e2p_r;
  logic signed [63:0] s77_p8lo_r, s79_p9lo_r, s79_e2_r, s80_e2_r, s80_e1_r;
  logic [31:0]        s77_lh_r, s77_p8hi_r, s79_p9hi_r, lh2;
  logic               inv_r [76:80];
  logic signed [63:0] rsum, r81;
  logic [31:0]        press81;

  assign q64  = div_quo_r[hptc_pkg::DIV_W];
  assign ps77 = p_r[76] >>> 13;
  assign lh2  = {s77_lh_r[30:0], 1'b0};
  assign rsum = p_r[80] + s80_e1_r + s80_e2_r;
  assign r81  = (rsum >>> 8) + ($signed({{48{p7[15]}}, p7}) <<< 4);

  // clamp to the unsigned 32 bit range
  always_comb begin
    if (inv_r[80] || r81[63])
      press81 = '0;
    else if (r81[63:32] != '0)
      press81 = '1;
    else
      press81 = r81[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[76]    <= div_neg_r[hptc_pkg::DIV_W] ? -q64 : q64;
      inv_r[76]  <= div_inv_r[hptc_pkg::DIV_W];
      for (int i = 77; i <= 80; i++) begin
        p_r[i]   <= p_r[i-1];
        inv_r[i] <= inv_r[i-1];
      end
      s77_ll_r   <= {32'b0, ps77[31:0]} * {32'b0, ps77[31:0]};
      s77_lh_r   <= ps77[31:0] * ps77[63:32];
      s77_p8lo_r <= hptc_pkg::part_lo(p_r[76][31:0], p8);
      s77_p8hi_r <= hptc_pkg::part_hi(p_r[76][63:32], p8);
      s78_psq_r  <= s77_ll_r + {lh2, 32'b0};
      s78_e2p_r  <= s77_p8lo_r + {s77_p8hi_r, 32'b0};
      s79_p9lo_r <= hptc_pkg::part_lo(s78_psq_r[31:0], p9);
      s79_p9hi_r <= hptc_pkg::part_hi(s78_psq_r[63:32], p9);
      s79_e2_r   <= s78_e2p_r >>> 19;
      s80_e2_r   <= s79_e2_r;
      s80_e1_r   <= $signed(s79_p9lo_r + {s79_p9hi_r, 32'b0}) >>> 25;
      // output register
      out_temperature_centi <= tt_r[hptc_pkg::TT_LEN-1].tc;
      out_fine_temperature  <= tt_r[hptc_pkg::TT_LEN-1].tf;
      out_humidity_q22_10   <= hum_r[hptc_pkg::HUM_LEN-1];
      out_pressure_q24_8    <= press81;
      out_pressure_invalid  <= inv_r[80];
    end
  end

  assign out_valid = vld_r[hptc_pkg::NSTG];

endmodule

// ===== rtl/hptc_checker.sv =====
// ---------------------------------------------------------------------------
// hptc_checker
// Port-level checks on the compensation pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module hptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_humidity_q22_10,
  input logic [31:0] out_pressure_q24_8,
  input logic        out_pressure_invalid
);

  // a stalled result stays valid and holds its pressure value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_q24_8))
    else $error("stalled result changed");

  // input side only backs up when a result is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // humidity never above 100 percent
  a_hum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q22_10 <= hptc_pkg::HUM_MAX)
    else $error("humidity out of range");

  // a zero divisor forces pressure to zero
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_invalid |-> out_pressure_q24_8 == '0)
    else $error("invalid pressure not zero");

endmodule

bind humidity_pressure_temp_compensation hptc_checker u_hptc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_humidity_q22_10  (out_humidity_q22_10),
  .out_pressure_q24_8   (out_pressure_q24_8),
  .out_pressure_invalid (out_pressure_invalid)
);
